FILE: hw/rtl/sms_user_data_header_parser_macros.svh
// Assertion macros used by the checker of the header parser
`ifndef SMS_USER_DATA_HEADER_PARSER_MACROS_SVH
`define SMS_USER_DATA_HEADER_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SUDH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define SUDH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/sudh_pkg.sv
package sudh_pkg;

  // Element classification
  typedef enum logic [3:0] {
    KIND_CONCAT   = 4'd0,
    KIND_VOICE    = 4'd1,
    KIND_FAX      = 4'd2,
    KIND_EMAIL    = 4'd3,
    KIND_RINGTONE = 4'd4,
    KIND_OP_LOGO  = 4'd5,
    KIND_CLI_ICON = 4'd6,
    KIND_CARD     = 4'd7,
    KIND_UNKNOWN  = 4'd8,
    KIND_NONE     = 4'd9
  } kind_t;

  // Information element identifiers
  localparam logic [7:0] IEI_CONCAT  = 8'h00;
  localparam logic [7:0] IEI_SPECIAL = 8'h01;
  localparam logic [7:0] IEI_PORT16  = 8'h05;

  // Special indication type, low bits of the first data byte
  localparam logic [1:0] SPC_VOICE = 2'd0;
  localparam logic [1:0] SPC_FAX   = 2'd1;
  localparam logic [1:0] SPC_EMAIL = 2'd2;

  // Destination ports of interest
  localparam logic [15:0] PORT_RINGTONE = 16'h1581;
  localparam logic [15:0] PORT_OP_LOGO  = 16'h1582;
  localparam logic [15:0] PORT_CLI_ICON = 16'h1583;
  localparam logic [15:0] PORT_CARD     = 16'h23f4;

  localparam int unsigned OUT_TDATA_W = 64;

  // Result tdata bit positions
  localparam int unsigned OD_ID_LSB    = 0;
  localparam int unsigned OD_REF_LSB   = 8;
  localparam int unsigned OD_TOTAL_LSB = 16;
  localparam int unsigned OD_CUR_LSB   = 24;
  localparam int unsigned OD_STORE_BIT = 32;
  localparam int unsigned OD_COUNT_LSB = 33;
  localparam int unsigned OD_INDEX_LSB = 41;
  localparam int unsigned OD_TRUNC_BIT = 48;
  localparam int unsigned OD_HLEN_LSB  = 49;

  function automatic kind_t sudh_kind(input logic [7:0] id, input logic [7:0] d0,
                                      input logic [7:0] d1);
    kind_t k;
    k = KIND_NONE;
    if (id == IEI_CONCAT) begin
      k = KIND_CONCAT;
    end else if (id == IEI_SPECIAL) begin
      case (d0[1:0])
        SPC_VOICE: k = KIND_VOICE;
        SPC_FAX:   k = KIND_FAX;
        SPC_EMAIL: k = KIND_EMAIL;
        default:   k = KIND_UNKNOWN;
      endcase
    end else if (id == IEI_PORT16) begin
      case ({d0, d1})
        PORT_RINGTONE: k = KIND_RINGTONE;
        PORT_OP_LOGO:  k = KIND_OP_LOGO;
        PORT_CLI_ICON: k = KIND_CLI_ICON;
        PORT_CARD:     k = KIND_CARD;
        default:       k = KIND_UNKNOWN;
      endcase
    end
    return k;
  endfunction

endpackage

FILE: hw/rtl/sms_user_data_header_parser.sv
// SMS user data header parser.
// Input channel (in_*): one header byte per item in in_tdata; in_tuser high marks
// the header length byte that opens a new header. Header start mid-header drops
// the open header silently; bytes outside a header are ignored.
// Result channel (out_*): one record per complete information element, or one
// record per element cut short by the header end (truncated bit set). An empty
// header gives a single record of kind "none". out_tlast marks the final record
// of a header.
// Path: the byte that completes an element passes the input register, then the
// parse logic into the result register, which offers the record; a stall on
// out_tready can hold the flow at either register.
// Throughput: one byte per cycle while the result channel is not stalled; the
// parse state advances once per byte through counter and compare logic only.
// Stall: while a record waits in the result register, one more byte may sit in
// the input register; after that in_tready drops until out_tready returns.
// Reset: both registers empty, parse state idle, nothing open.
module sms_user_data_header_parser
  import sudh_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] data_byte
  input  logic                   in_tuser,   // [0] header_start
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [7:0] element_identifier, [15:8] reference_number, [23:16] total_parts,
  // [31:24] current_part, [32] store_flag, [40:33] message_count,
  // [47:41] element_index, [48] truncated, [57:49] header_total_length, rest 0
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [3:0]             out_tuser,  // [3:0] element_kind
  output logic                   out_tlast   // last_element
);

  typedef enum logic [1:0] {PH_IDLE, PH_IDENT, PH_LEN, PH_DATA} phase_t;

  // Input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_start_r;

  // Parse state
  phase_t          phase_r, phase_nxt;
  logic [7:0]      hbl_r, hbl_nxt;
  logic [8:0]      hlen_r, hlen_nxt;
  logic [7:0]      id_r, id_nxt;
  logic [7:0]      ebl_r, ebl_nxt;
  logic [1:0]      pos_r, pos_nxt;
  logic [2:0][7:0] cap_r, cap_nxt;
  logic [6:0]      cnt_r, cnt_nxt, cnt_base;

  // Result register
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic [3:0]             out_kind_r, out_kind_nxt;
  logic                   out_last_r, out_last_nxt;

  logic       advance, go, emit, trunc, last, force_none;
  logic [7:0] hbl_dec, ebl_dec;
  kind_t      kind;
  logic       is_concat, is_special;

  assign advance   = !out_valid_r || out_tready;
  assign go        = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  assign hbl_dec = hbl_r - 8'd1;
  assign ebl_dec = ebl_r - 8'd1;

  // Per-byte parse step
  always_comb begin
    phase_nxt  = phase_r;
    hbl_nxt    = hbl_r;
    hlen_nxt   = hlen_r;
    id_nxt     = id_r;
    ebl_nxt    = ebl_r;
    pos_nxt    = pos_r;
    cap_nxt    = cap_r;
    cnt_base   = cnt_r;
    emit       = 1'b0;
    trunc      = 1'b0;
    last       = 1'b0;
    force_none = 1'b0;
    if (go) begin
      if (s1_start_r) begin
        hbl_nxt  = s1_byte_r;
        hlen_nxt = {1'b0, s1_byte_r} + 9'd1;
        cnt_base = '0;
        id_nxt   = '0;
        ebl_nxt  = '0;
        pos_nxt  = '0;
        cap_nxt  = '0;
        if (s1_byte_r == 8'd0) begin
          emit       = 1'b1;
          last       = 1'b1;
          force_none = 1'b1;
        end else begin
          phase_nxt = PH_IDENT;
        end
      end else begin
        unique case (phase_r)
          PH_IDENT: begin
            id_nxt  = s1_byte_r;
            ebl_nxt = '0;
            pos_nxt = '0;
            cap_nxt = '0;
            hbl_nxt = hbl_dec;
            if (hbl_dec == 8'd0) begin
              emit  = 1'b1;
              trunc = 1'b1;
              last  = 1'b1;
            end else begin
              phase_nxt = PH_LEN;
            end
          end
          PH_LEN: begin
            ebl_nxt = s1_byte_r;
            hbl_nxt = hbl_dec;
            if (s1_byte_r == 8'd0) begin
              emit = 1'b1;
              last = (hbl_dec == 8'd0);
            end else if (hbl_dec == 8'd0) begin
              emit  = 1'b1;
              trunc = 1'b1;
              last  = 1'b1;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
          PH_DATA: begin
            // only the first three data bytes are kept
            case (pos_r)
              2'd0:    cap_nxt[0] = s1_byte_r;
              2'd1:    cap_nxt[1] = s1_byte_r;
              2'd2:    cap_nxt[2] = s1_byte_r;
              default: cap_nxt = cap_r;
            endcase
            if (pos_r != 2'd3) pos_nxt = pos_r + 2'd1;
            ebl_nxt = ebl_dec;
            hbl_nxt = hbl_dec;
            if (ebl_dec == 8'd0) begin
              emit = 1'b1;
              last = (hbl_dec == 8'd0);
            end else if (hbl_dec == 8'd0) begin
              emit  = 1'b1;
              trunc = 1'b1;
              last  = 1'b1;
            end
          end
          PH_IDLE: begin
            phase_nxt = PH_IDLE;
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
      if (emit) phase_nxt = last ? PH_IDLE : PH_IDENT;
    end
    cnt_nxt = emit ? cnt_base + 7'd1 : cnt_base;
  end

  // Record assembly from the post-update element state
  assign is_concat  = (id_nxt == IEI_CONCAT);
  assign is_special = (id_nxt == IEI_SPECIAL);
  assign kind       = force_none ? KIND_NONE : sudh_kind(id_nxt, cap_nxt[0], cap_nxt[1]);

  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[OD_ID_LSB    +: 8] = id_nxt;
    out_data_nxt[OD_REF_LSB   +: 8] = is_concat ? cap_nxt[0] : 8'd0;
    out_data_nxt[OD_TOTAL_LSB +: 8] = is_concat ? cap_nxt[1] : 8'd0;
    out_data_nxt[OD_CUR_LSB   +: 8] = is_concat ? cap_nxt[2] : 8'd0;
    out_data_nxt[OD_STORE_BIT]      = is_special & cap_nxt[0][7];
    out_data_nxt[OD_COUNT_LSB +: 8] = is_special ? cap_nxt[1] : 8'd0;
    out_data_nxt[OD_INDEX_LSB +: 7] = cnt_base;
    out_data_nxt[OD_TRUNC_BIT]      = trunc;
    out_data_nxt[OD_HLEN_LSB  +: 9] = hlen_nxt;
    out_kind_nxt = 4'(kind);
    out_last_nxt = last;
  end

  // Valid tracking for the two register stages
  always_comb begin
    if (in_tvalid && in_tready) s1_valid_nxt = 1'b1;
    else if (advance)           s1_valid_nxt = 1'b0;
    else                        s1_valid_nxt = s1_valid_r;
    out_valid_nxt = advance ? (go && emit) : out_valid_r;
  end

  // Control and parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_IDLE;
      hbl_r       <= '0;
      hlen_r      <= 9'd1;
      id_r        <= '0;
      ebl_r       <= '0;
      pos_r       <= '0;
      cap_r       <= '0;
      cnt_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
      hbl_r       <= hbl_nxt;
      hlen_r      <= hlen_nxt;
      id_r        <= id_nxt;
      ebl_r       <= ebl_nxt;
      pos_r       <= pos_nxt;
      cap_r       <= cap_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r  <= in_tdata;
      s1_start_r <= in_tuser;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
      out_kind_r <= out_kind_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: hw/rtl/sudh_checker.sv
`include "sms_user_data_header_parser_macros.svh"

module sudh_checker
  import sudh_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [3:0]             out_tuser,
  input logic                   out_tlast
);

  logic       rec_trunc;
  logic [6:0] rec_index;
  logic [8:0] rec_hlen;

  assign rec_trunc = out_tdata[OD_TRUNC_BIT];
  assign rec_index = out_tdata[OD_INDEX_LSB +: 7];
  assign rec_hlen  = out_tdata[OD_HLEN_LSB +: 9];

  // A waiting record stays put
  `SUDH_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast),
    "record changed while stalled")

  // An element cut by the header end always closes the header
  `SUDH_ASSERT_NOW(a_trunc_last, clk, rst_n, out_tvalid && rec_trunc, out_tlast,
    "truncated record not marked last")

  // Every element index stays below the header total length
  `SUDH_ASSERT_NOW(a_index_fits, clk, rst_n, out_tvalid, {2'b00, rec_index} < rec_hlen,
    "element index beyond header length")

  // An empty header gives exactly one record of kind none
  `SUDH_ASSERT_NOW(a_empty_hdr, clk, rst_n, out_tvalid && rec_hlen == 9'd1,
    out_tlast && rec_index == 7'd0 && out_tuser == KIND_NONE && !rec_trunc,
    "empty header record malformed")

endmodule

bind sms_user_data_header_parser sudh_checker u_sudh_checker (.*);
